// ===== design/lpps_pkg.sv =====
// Shared types, widths, register codes and reset values for the LED pattern PWM sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lpps_pkg;

  // Default width of the pattern counter
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int PEAK_W  = 16;
  localparam int STEP_W  = 8;
  localparam int LUM_W   = 9;
  localparam int MODE_W  = 2;
  localparam int DUTY_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [PEAK_W-1:0] PEAK_RST = 16'd1023;
  localparam logic [STEP_W-1:0] STEP_RST = 8'd8;
  localparam logic [LUM_W-1:0]  LUM_RST  = 9'd256;

  // Saturation limit of the duty word
  localparam logic [DUTY_W-1:0] DUTY_MAX = 16'hFFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LUM  = 2'd2;

  // LED pattern codes
  typedef enum logic [MODE_W-1:0] {
    MODE_OFF  = 2'd0,
    MODE_SOFT = 2'd1,
    MODE_ON   = 2'd2,
    MODE_HARD = 2'd3
  } mode_t;

  // Per-cycle control to the pattern counter
  typedef struct packed {
    logic  advance;
    mode_t mode;
  } pat_ctl_t;

  // Pattern settings
  typedef struct packed {
    logic [PEAK_W-1:0] peak;
    logic [STEP_W-1:0] step;
  } pat_cfg_t;

endpackage

`default_nettype wire

// ===== design/lpps_pattern.sv =====
// Pattern counter state and level generation for the four LED modes.
`timescale 1ns / 1ps
`default_nettype none

module lpps_pattern #(
  parameter int COUNT_WIDTH = lpps_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lpps_pkg::pat_ctl_t     ctl,
  input  wire lpps_pkg::pat_cfg_t     cfg,
  output logic [COUNT_WIDTH-1:0]      level
);

  // compare width covers both the counter and the 16-bit peak
  localparam int CMP_W = (COUNT_WIDTH > lpps_pkg::PEAK_W) ? COUNT_WIDTH : lpps_pkg::PEAK_W;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   ramp_up_r, ramp_up_nxt;
  lpps_pkg::mode_t        mode_r;

  logic [COUNT_WIDTH-1:0] count_base;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [COUNT_WIDTH-1:0] step_w;
  logic [COUNT_WIDTH-1:0] peak_w;
  logic [CMP_W-1:0]       count_cmp;
  logic [CMP_W-1:0]       inc_cmp;
  logic [CMP_W-1:0]       peak_cmp;
  logic [CMP_W-1:0]       half_cmp;

  always_comb begin
    // mode change restarts the count
    count_base = (ctl.mode != mode_r) ? '0 : count_r;
    step_w     = COUNT_WIDTH'(cfg.step);
    peak_w     = COUNT_WIDTH'(cfg.peak);
    count_inc  = count_base + COUNT_WIDTH'(1);
    count_cmp  = CMP_W'(count_base);
    inc_cmp    = CMP_W'(count_inc);
    peak_cmp   = CMP_W'(cfg.peak);
    half_cmp   = CMP_W'(cfg.peak >> 1);

    count_nxt   = count_base;
    ramp_up_nxt = ramp_up_r;
    level       = '0;

    case (ctl.mode)
      lpps_pkg::MODE_SOFT: begin
        if (ramp_up_r) begin
          if (count_cmp < peak_cmp) begin
            count_nxt = count_base + step_w;
          end else begin
            ramp_up_nxt = 1'b0;
          end
        end else begin
          if (count_base != '0) begin
            count_nxt = count_base - step_w;
          end else begin
            ramp_up_nxt = 1'b1;
          end
        end
        level = count_nxt;
      end
      lpps_pkg::MODE_ON: begin
        count_nxt = peak_w + COUNT_WIDTH'(1);
        level     = count_nxt;
      end
      lpps_pkg::MODE_HARD: begin
        // blink at 1/32 of the count during the first half of the period
        if ((count_cmp < half_cmp) && count_base[4]) begin
          level = peak_w;
        end
        count_nxt = (inc_cmp > peak_cmp) ? '0 : count_inc;
      end
      default: begin
        count_nxt = '0;
        level     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ramp_up_r <= 1'b1;
      mode_r    <= lpps_pkg::MODE_OFF;
    end else if (ctl.advance) begin
      count_r   <= count_nxt;
      ramp_up_r <= ramp_up_nxt;
      mode_r    <= ctl.mode;
    end
  end

  a_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.advance |=> (mode_r == $past(ctl.mode)))
    else $error("stored mode did not follow the advanced word");

  a_on_level: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.advance && (ctl.mode == lpps_pkg::MODE_ON))
      |=> (count_r == ($past(peak_w) + COUNT_WIDTH'(1))))
    else $error("on mode count is not peak plus one");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.advance |=> ($stable(count_r) && $stable(ramp_up_r)))
    else $error("pattern state moved without an advance");

endmodule

`default_nettype wire

// ===== design/lpps_scale.sv =====
// Luminance scaling of the pattern level with truncation and saturation.
`timescale 1ns / 1ps
`default_nettype none

module lpps_scale #(
  parameter int COUNT_WIDTH = lpps_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic [COUNT_WIDTH-1:0]         level,
  input  wire logic [lpps_pkg::LUM_W-1:0]     luminance,
  output logic      [lpps_pkg::DUTY_W-1:0]    duty
);

  localparam int PROD_W = COUNT_WIDTH + lpps_pkg::LUM_W;
  localparam int SCL_W  = PROD_W - 8;
  localparam int SAT_W  = (SCL_W > lpps_pkg::DUTY_W) ? SCL_W : lpps_pkg::DUTY_W + 1;

  logic [PROD_W-1:0] prod;
  logic [SAT_W-1:0]  scaled;

  always_comb begin
    prod   = PROD_W'(level) * PROD_W'(luminance);
    scaled = SAT_W'(prod[PROD_W-1:8]);
    duty   = (scaled > SAT_W'(lpps_pkg::DUTY_MAX)) ? lpps_pkg::DUTY_MAX
                                                   : scaled[lpps_pkg::DUTY_W-1:0];
  end

endmodule

`default_nettype wire

// ===== design/led_pattern_pwm_sequencer.sv =====
// Top level of the LED pattern PWM sequencer: registers, pipeline and handshakes.
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake         | word
//  --------+-----------+-------------------+------------------------------------
//  in_     | input     | in_valid/in_stall | compare_event, mode
//  out_    | output    | out_valid/out_stall| duty
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One word per clock sustained while out_stall is low. From acceptance to
//  out_valid a word passes the input register, the pattern stage (level
//  register) and the scaling stage (output register). The count update loop
//  in the pattern stage sets the rate. Synchronous active-low reset clears the
//  pipeline valids and pattern state and loads the settings' reset values.
//  out_stall backs up combinationally; a stage with room keeps taking words.

module led_pattern_pwm_sequencer #(
  parameter int COUNT_WIDTH = lpps_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input words
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_compare_event,
  input  wire logic [lpps_pkg::MODE_W-1:0]       in_mode,
  // result words
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [lpps_pkg::DUTY_W-1:0]       out_duty,
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lpps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lpps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // settings
  logic [lpps_pkg::PEAK_W-1:0] peak_r;
  logic [lpps_pkg::STEP_W-1:0] step_r;
  logic [lpps_pkg::LUM_W-1:0]  lum_r;

  // input register
  logic                        s1_valid_r;
  logic                        s1_event_r;
  lpps_pkg::mode_t             s1_mode_r;

  // level register
  logic                        lvl_valid_r;
  logic [COUNT_WIDTH-1:0]      lvl_r, lvl_nxt;

  // output register
  logic                        out_valid_r;
  logic [lpps_pkg::DUTY_W-1:0] out_duty_r, duty_nxt;

  logic                        s1_ready, s2_ready, s3_ready;
  logic                        in_accept, s1_adv, s2_adv;
  logic [COUNT_WIDTH-1:0]      pat_level;
  lpps_pkg::pat_ctl_t          pat_ctl;
  lpps_pkg::pat_cfg_t          pat_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= lpps_pkg::PEAK_RST;
      step_r <= lpps_pkg::STEP_RST;
      lum_r  <= lpps_pkg::LUM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpps_pkg::CFG_PEAK: peak_r <= cfg_data[lpps_pkg::PEAK_W-1:0];
        lpps_pkg::CFG_STEP: step_r <= cfg_data[lpps_pkg::STEP_W-1:0];
        lpps_pkg::CFG_LUM:  lum_r  <= cfg_data[lpps_pkg::LUM_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // per-stage ready: a stage takes a word when empty or when it drains
  assign s3_ready  = !out_valid_r || !out_stall;
  assign s2_ready  = !lvl_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;
  assign s1_adv    = s1_valid_r && s2_ready;
  assign s2_adv    = lvl_valid_r && s3_ready;

  // pattern state only moves on a word with the compare flag
  assign pat_ctl.advance = s1_adv && s1_event_r;
  assign pat_ctl.mode    = s1_mode_r;
  assign pat_cfg.peak    = peak_r;
  assign pat_cfg.step    = step_r;

  lpps_pattern #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_pattern (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pat_ctl),
    .cfg   (pat_cfg),
    .level (pat_level)
  );

  assign lvl_nxt = s1_event_r ? pat_level : '0;

  lpps_scale #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scale (
    .level     (lvl_r),
    .luminance (lum_r),
    .duty      (duty_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      lvl_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        lvl_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        out_valid_r <= lvl_valid_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_event_r <= in_compare_event;
      s1_mode_r  <= lpps_pkg::mode_t'(in_mode);
    end
    if (s1_adv) begin
      lvl_r <= lvl_nxt;
    end
    if (s2_adv) begin
      out_duty_r <= duty_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_no_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_event_r) |=> (lvl_r == '0))
    else $error("word without compare flag gave a nonzero level");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv |=> out_valid_r)
    else $error("level word lost on its way to the output register");

endmodule

`default_nettype wire

// ===== bench/lpps_duty_checker.sv =====
// Duty predictor and result checker for the LED pattern PWM sequencer bench.
`timescale 1ns / 1ps

module lpps_duty_checker
  import lpps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_compare_event,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [DUTY_W-1:0]     out_duty,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  // settings as last written
  logic [PEAK_W-1:0] peak;
  logic [STEP_W-1:0] step;
  logic [LUM_W-1:0]  lum;

  // pattern state
  logic [15:0] cnt;
  logic        rising;
  mode_t       cur_mode;

  logic [DUTY_W-1:0] duty_q[$];
  logic [DUTY_W-1:0] want;

  // one tick of the pattern, returns the scaled duty; no flag gives zero and no tick
  function automatic logic [DUTY_W-1:0] next_duty(input logic flag, input mode_t req);
    logic [15:0] lvl;
    logic [24:0] prod;
    if (!flag) return '0;
    if (req != cur_mode) begin
      cnt = '0;
      cur_mode = req;
    end
    lvl = '0;
    case (cur_mode)
      MODE_SOFT: begin
        if (rising) begin
          if (cnt < peak) cnt = cnt + step;
          else rising = 1'b0;
        end else begin
          if (cnt != '0) cnt = cnt - step;
          else rising = 1'b1;
        end
        lvl = cnt;
      end
      MODE_ON: begin
        cnt = peak + 16'd1;
        lvl = cnt;
      end
      MODE_HARD: begin
        if (cnt < (peak >> 1) && cnt[4]) lvl = peak;
        cnt = cnt + 16'd1;
        if (cnt > peak) cnt = '0;
      end
      default: cnt = '0;
    endcase
    prod = lvl * lum;
    prod = prod >> 8;
    if (prod > DUTY_MAX) return DUTY_MAX;
    return prod[DUTY_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      peak = PEAK_RST;
      step = STEP_RST;
      lum = LUM_RST;
      cnt = '0;
      rising = 1'b1;
      cur_mode = MODE_OFF;
      duty_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PEAK: peak = cfg_data[PEAK_W-1:0];
          CFG_STEP: step = cfg_data[STEP_W-1:0];
          CFG_LUM:  lum = cfg_data[LUM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (duty_q.size() == 0) begin
          $error("duty: expected none, got %0d", out_duty);
          fail_count++;
        end else begin
          want = duty_q.pop_front();
          if (out_duty !== want) begin
            $error("duty: expected %0d, got %0d", want, out_duty);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        duty_q.push_back(next_duty(in_compare_event, mode_t'(in_mode)));
      pending <= duty_q.size();
    end
  end

endmodule

// ===== bench/tb_led_pattern_pwm_sequencer.sv =====
// Stimulus, handshake pacing and verdict for the LED pattern PWM sequencer.
`timescale 1ns / 1ps

module tb_led_pattern_pwm_sequencer;
  import lpps_pkg::*;

  // cycles with no word moving on any channel before we give up
  localparam int STUCK_LIMIT = 2000;
  localparam int WORDS_PER_PHASE = 200;
  localparam int PHASES = 8;

  // index past the register list
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_compare_event;
  logic [MODE_W-1:0]     in_mode;
  logic                  out_valid;
  logic                  out_stall;
  logic [DUTY_W-1:0]     out_duty;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int stuck;
  bit idle_on;

  led_pattern_pwm_sequencer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_compare_event (in_compare_event),
    .in_mode          (in_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty         (out_duty),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // predicts every accepted word and compares the duty words coming out
  lpps_duty_checker i_duty_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_compare_event (in_compare_event),
    .in_mode          (in_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty         (out_duty),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one tick word. Now and then the sender goes quiet for a burst first.
  // Returns at the falling edge after the word was taken; valid stays up so a
  // following word rides straight behind it.
  task automatic put_word(input logic flag, input mode_t m);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_compare_event <= flag;
    in_mode <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted duty word has come back.
  // An idle wait after that covers the three-stage pipe before settings change.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits carry junk on the narrow registers; only the low bits count
  task automatic set_regs(input logic [PEAK_W-1:0] pk, input logic [STEP_W-1:0] st,
                          input logic [LUM_W-1:0] lm);
    drain();
    write_reg(CFG_PEAK, pk);
    write_reg(CFG_STEP, {8'($urandom), st});
    write_reg(CFG_LUM, {7'($urandom), lm});
  endtask

  // result side: random stall bursts while idling is allowed
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: any word moving on any channel resets the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("tb_led_pattern_pwm_sequencer: errors");
      $finish;
    end
  end

  initial begin
    logic [PEAK_W-1:0] pk;
    logic [STEP_W-1:0] st;
    logic [LUM_W-1:0]  lm;
    mode_t m;
    int sent;
    int run_len;
    bit noisy;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_compare_event = 1'b0;
    in_mode = MODE_OFF;
    cfg_valid = 1'b0;
    cfg_index = CFG_PEAK;
    cfg_data = '0;
    stuck = 0;
    idle_on = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed: reset settings, every mode, flag low, mode switches
    put_word(1'b0, MODE_HARD);      // no flag before anything ran
    put_word(1'b1, MODE_OFF);
    repeat (3) put_word(1'b1, MODE_SOFT);
    put_word(1'b0, MODE_ON);        // flag low must leave the ramp alone
    put_word(1'b1, MODE_SOFT);
    repeat (2) put_word(1'b1, MODE_ON);
    repeat (4) put_word(1'b1, MODE_HARD);
    put_word(1'b1, MODE_OFF);

    // zero peak, zero step, luminance past full scale
    set_regs(16'd0, 8'd0, 9'd511);
    repeat (3) put_word(1'b1, MODE_SOFT);
    put_word(1'b1, MODE_ON);
    repeat (2) put_word(1'b1, MODE_HARD);

    // top peak: on level hits the saturation of the scaled duty
    set_regs(16'd65534, 8'd255, 9'd511);
    write_reg(CFG_UNMAPPED, 16'($urandom)); // no such register, must change nothing
    put_word(1'b1, MODE_ON);
    repeat (2) put_word(1'b1, MODE_SOFT);
    repeat (2) put_word(1'b1, MODE_HARD);

    // --- random phases, each with its own settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          pk = 16'($urandom_range(20, 200));
          st = 8'($urandom_range(1, 16));
          lm = 9'd256;
        end
        1: begin pk = 16'd65534; st = 8'd255; lm = 9'd256; end
        2: begin pk = 16'd1; st = 8'd1; lm = 9'd0; end
        3: begin pk = 16'($urandom_range(1, 300)); st = 8'd0; lm = 9'd511; end
        4: begin
          pk = 16'd65535;
          st = 8'($urandom_range(0, 255));
          lm = 9'($urandom_range(257, 511));
        end
        5: begin
          pk = 16'($urandom_range(0, 65535));
          st = 8'($urandom_range(0, 255));
          lm = 9'($urandom_range(0, 511));
        end
        default: begin
          pk = 16'($urandom_range(1, 500));
          st = 8'($urandom_range(0, 255));
          lm = 9'($urandom_range(0, 511));
        end
      endcase
      set_regs(pk, st, lm);
      // last phase runs at full rate on both sides
      if (ph == PHASES - 1) idle_on = 1'b0;
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        // mostly long runs of one mode so ramps and blinks get far along;
        // the rest are short bursts of mixed modes and dropped flags
        noisy = ($urandom_range(0, 6) == 0);
        run_len = noisy ? $urandom_range(1, 4) : $urandom_range(8, 120);
        m = mode_t'($urandom_range(0, 3));
        for (int k = 0; k < run_len && sent < WORDS_PER_PHASE; k++) begin
          if (noisy) begin
            put_word(1'($urandom), mode_t'($urandom_range(0, 3)));
          end else begin
            put_word($urandom_range(0, 9) != 0, m);
          end
          sent++;
        end
      end
    end

    // wait out everything still in flight, then idle on to catch strays
    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_led_pattern_pwm_sequencer: clean");
    end else begin
      $display("tb_led_pattern_pwm_sequencer: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lpps_pkg.sv
design/lpps_pattern.sv
design/lpps_scale.sv
design/led_pattern_pwm_sequencer.sv
bench/lpps_duty_checker.sv
bench/tb_led_pattern_pwm_sequencer.sv
